// ===== rtl/core/gpsm_pkg.sv =====
// shared types, constants and helpers of the game controller poll master
package gpsm_pkg;

  // field widths
  localparam int unsigned TickW  = 10;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned BitIdxW  = 3;
  localparam int unsigned ByteIdxW = 4;
  localparam int unsigned NumData  = 6;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 64;

  // configuration register indexes
  localparam logic [CfgAddrW-1:0] RegHalfBit  = 3'd0;
  localparam logic [CfgAddrW-1:0] RegLead     = 3'd1;
  localparam logic [CfgAddrW-1:0] RegRelease  = 3'd2;
  localparam logic [CfgAddrW-1:0] RegDigital  = 3'd3;
  localparam logic [CfgAddrW-1:0] RegAnalog   = 3'd4;

  // reset values of the configuration registers
  localparam logic [TickW-1:0] HalfBitRst  = 10'd50;
  localparam logic [TickW-1:0] LeadRst     = 10'd10;
  localparam logic [TickW-1:0] ReleaseRst  = 10'd5;
  localparam logic [ByteW-1:0] DigitalRst  = 8'd65;
  localparam logic [ByteW-1:0] AnalogRst   = 8'd115;

  // command bytes and stored byte reset
  localparam logic [ByteW-1:0] CmdStart = 8'h01;
  localparam logic [ByteW-1:0] CmdPoll  = 8'h42;
  localparam logic [ByteW-1:0] CmdIdle  = 8'h00;
  localparam logic [ByteW-1:0] DataRst  = 8'hFF;

  // index of the last byte of a transaction for each mode, and other byte and bit positions
  localparam logic [ByteIdxW-1:0] LastDigital = 4'd4;
  localparam logic [ByteIdxW-1:0] LastAnalog  = 4'd8;
  localparam logic [ByteIdxW-1:0] LastOther   = 4'd1;
  localparam logic [ByteIdxW-1:0] ModeByteIdx = 4'd1;
  localparam logic [ByteIdxW-1:0] FirstData   = 4'd3;
  localparam logic [ByteIdxW-1:0] LastData    = 4'd8;
  localparam logic [BitIdxW-1:0]  LastBit     = 3'd7;

  // transaction phase, one-hot
  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_LEAD = 5'b00010,
    PH_LOW  = 5'b00100,
    PH_HIGH = 5'b01000,
    PH_REL  = 5'b10000
  } phase_t;

  // configuration registers as seen by the engine
  typedef struct packed {
    logic [TickW-1:0] half_bit_ticks;
    logic [TickW-1:0] select_lead_ticks;
    logic [TickW-1:0] release_ticks;
    logic [ByteW-1:0] digital_mode_id;
    logic [ByteW-1:0] analog_mode_id;
  } cfg_t;

  // one result word
  typedef struct packed {
    logic             clock_out;
    logic             data_out;
    logic             select_n;
    logic             busy_res;
    logic             poll_done;
    logic [ByteW-1:0] mode_byte;
    logic [ByteW-1:0] buttons_low;
    logic [ByteW-1:0] buttons_high;
    logic [ByteW-1:0] right_x;
    logic [ByteW-1:0] right_y;
    logic [ByteW-1:0] left_x;
    logic [ByteW-1:0] left_y;
  } result_t;

  // bit of the command byte sent at a given byte and bit position
  function automatic logic cmd_bit(input logic [ByteIdxW-1:0] byte_idx,
                                   input logic [BitIdxW-1:0] bit_idx);
    logic [ByteW-1:0] tx;
    case (byte_idx)
      4'd0:    tx = CmdStart;
      4'd1:    tx = CmdPoll;
      default: tx = CmdIdle;
    endcase
    return tx[bit_idx];
  endfunction

endpackage

// ===== rtl/core/gamepad_poll_spi_master_top.sv =====
// top level of the game controller poll master: stream ports and staging registers
//
// Each input word is one timing tick of the serial engine and produces exactly one
// result word carrying the pin levels, busy and done flags and the stored bytes as
// they stand after that tick. One word is taken per clock cycle whenever the result
// side keeps up; each word passes through the input register and then the engine's
// single-pass update into the output register. While a result waits in the output
// register, an empty input register can still take a new word. Configuration writes
// take effect on the next cycle and are meant to be made while no words are in flight.
module gamepad_poll_spi_master_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [gpsm_pkg::InDataW-1:0]        in_tdata,   // [0] start_poll, [1] data_in
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [gpsm_pkg::OutDataW-1:0]       out_tdata,  // [0] clock_out, [1] data_out,
                                                          // [2] select_n, [3] busy_res,
                                                          // [11:4] mode_byte,
                                                          // [19:12] buttons_low,
                                                          // [27:20] buttons_high,
                                                          // [35:28] right_x, [43:36] right_y,
                                                          // [51:44] left_x, [59:52] left_y
  output logic                                out_tlast,  // poll_done
  // configuration
  input  logic                                cfg_we,
  input  logic [gpsm_pkg::CfgAddrW-1:0]       cfg_addr,
  input  logic [gpsm_pkg::CfgDataW-1:0]       cfg_wdata
);

  gpsm_pkg::cfg_t    cfg;
  gpsm_pkg::result_t res;

  logic s1_valid_r;
  logic s1_start_r;
  logic s1_din_r;
  logic out_valid_r;
  logic out_last_r;
  logic [gpsm_pkg::OutDataW-1:0] out_data_r;
  logic [gpsm_pkg::OutDataW-1:0] out_data_nxt;
  logic adv;
  logic in_take;

  // handshake: the engine steps when the staged word can reach the output register
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_take   = in_tvalid && in_tready;

  gpsm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  gpsm_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_i  (adv),
    .start_i (s1_start_r),
    .din_i   (s1_din_r),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_start_r <= in_tdata[0];
      s1_din_r   <= in_tdata[1];
    end
  end

  // pack the result word
  assign out_data_nxt = {4'd0, res.left_y, res.left_x, res.right_y, res.right_x,
                         res.buttons_high, res.buttons_low, res.mode_byte,
                         res.busy_res, res.select_n, res.data_out, res.clock_out};

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
      out_last_r <= res.poll_done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/core/gpsm_cfg.sv =====
// configuration register bank of the game controller poll master
module gpsm_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [gpsm_pkg::CfgAddrW-1:0]    cfg_addr,
  input  logic [gpsm_pkg::CfgDataW-1:0]    cfg_wdata,
  output gpsm_pkg::cfg_t                   cfg_o
);

  gpsm_pkg::cfg_t cfg_r;
  gpsm_pkg::cfg_t cfg_nxt;

  // decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        gpsm_pkg::RegHalfBit: cfg_nxt.half_bit_ticks    = cfg_wdata;
        gpsm_pkg::RegLead:    cfg_nxt.select_lead_ticks = cfg_wdata;
        gpsm_pkg::RegRelease: cfg_nxt.release_ticks     = cfg_wdata;
        gpsm_pkg::RegDigital: cfg_nxt.digital_mode_id   = cfg_wdata[gpsm_pkg::ByteW-1:0];
        gpsm_pkg::RegAnalog:  cfg_nxt.analog_mode_id    = cfg_wdata[gpsm_pkg::ByteW-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_bit_ticks    <= gpsm_pkg::HalfBitRst;
      cfg_r.select_lead_ticks <= gpsm_pkg::LeadRst;
      cfg_r.release_ticks     <= gpsm_pkg::ReleaseRst;
      cfg_r.digital_mode_id   <= gpsm_pkg::DigitalRst;
      cfg_r.analog_mode_id    <= gpsm_pkg::AnalogRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

// ===== rtl/core/gpsm_engine.sv =====
// per-tick state update of the serial poll engine
module gpsm_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_i,
  input  logic                start_i,
  input  logic                din_i,
  input  gpsm_pkg::cfg_t      cfg_i,
  output gpsm_pkg::result_t   res_o
);

  gpsm_pkg::phase_t                     phase_r, phase_nxt;
  logic [gpsm_pkg::TickW-1:0]           tick_r, tick_nxt;
  logic [gpsm_pkg::BitIdxW-1:0]         bit_r, bit_nxt;
  logic [gpsm_pkg::ByteIdxW-1:0]        byte_r, byte_nxt;
  logic [gpsm_pkg::ByteW-1:0]           shift_r, shift_nxt;
  logic [gpsm_pkg::ByteW-1:0]           mode_r, mode_nxt;
  logic [gpsm_pkg::ByteW-1:0]           data_r [gpsm_pkg::NumData];
  logic [gpsm_pkg::ByteW-1:0]           data_nxt [gpsm_pkg::NumData];
  logic                                 sel_r, sel_nxt;
  logic                                 sdo_r, sdo_nxt;
  logic                                 sck_r, sck_nxt;
  logic                                 done;
  logic [gpsm_pkg::ByteW-1:0]           shift_done;
  logic [gpsm_pkg::ByteIdxW-1:0]        byte_m3;
  logic [gpsm_pkg::ByteIdxW-1:0]        byte_inc;
  logic [gpsm_pkg::ByteIdxW-1:0]        last_idx;

  assign byte_m3  = byte_r - gpsm_pkg::FirstData;
  assign byte_inc = byte_r + 4'd1;

  // next state for one tick
  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    bit_nxt   = bit_r;
    byte_nxt  = byte_r;
    shift_nxt = shift_r;
    mode_nxt  = mode_r;
    data_nxt  = data_r;
    sel_nxt   = sel_r;
    sdo_nxt   = sdo_r;
    sck_nxt   = sck_r;
    done      = 1'b0;
    shift_done = shift_r | (gpsm_pkg::ByteW'(din_i) << bit_r);
    last_idx  = gpsm_pkg::LastOther;

    case (phase_r)
      gpsm_pkg::PH_LEAD: begin
        if (tick_r >= cfg_i.select_lead_ticks) begin
          sdo_nxt   = gpsm_pkg::cmd_bit(byte_r, bit_r);
          sck_nxt   = 1'b0;
          phase_nxt = gpsm_pkg::PH_LOW;
          tick_nxt  = 10'd1;
        end else begin
          tick_nxt = tick_r + 10'd1;
        end
      end
      gpsm_pkg::PH_LOW: begin
        if (tick_r >= cfg_i.half_bit_ticks) begin
          sck_nxt   = 1'b1;
          phase_nxt = gpsm_pkg::PH_HIGH;
          tick_nxt  = 10'd1;
        end else begin
          tick_nxt = tick_r + 10'd1;
        end
      end
      gpsm_pkg::PH_HIGH: begin
        if (tick_r >= cfg_i.half_bit_ticks) begin
          shift_nxt = shift_done;
          if (bit_r != gpsm_pkg::LastBit) begin
            // next bit of the same byte
            bit_nxt   = bit_r + 3'd1;
            sdo_nxt   = gpsm_pkg::cmd_bit(byte_r, bit_r + 3'd1);
            sck_nxt   = 1'b0;
            phase_nxt = gpsm_pkg::PH_LOW;
            tick_nxt  = 10'd1;
          end else begin
            // byte complete: store it and pick the next step
            if (byte_r == gpsm_pkg::ModeByteIdx) mode_nxt = shift_done;
            if (byte_r inside {[gpsm_pkg::FirstData:gpsm_pkg::LastData]})
              data_nxt[byte_m3[2:0]] = shift_done;
            if (mode_nxt == cfg_i.digital_mode_id)     last_idx = gpsm_pkg::LastDigital;
            else if (mode_nxt == cfg_i.analog_mode_id) last_idx = gpsm_pkg::LastAnalog;
            else                                       last_idx = gpsm_pkg::LastOther;
            if (byte_r >= last_idx) begin
              phase_nxt = gpsm_pkg::PH_REL;
              tick_nxt  = 10'd0;
            end else begin
              byte_nxt  = byte_inc;
              bit_nxt   = 3'd0;
              shift_nxt = 8'd0;
              sdo_nxt   = gpsm_pkg::cmd_bit(byte_inc, 3'd0);
              sck_nxt   = 1'b0;
              phase_nxt = gpsm_pkg::PH_LOW;
              tick_nxt  = 10'd1;
            end
          end
        end else begin
          tick_nxt = tick_r + 10'd1;
        end
      end
      gpsm_pkg::PH_REL: begin
        if (tick_r >= cfg_i.release_ticks) begin
          sel_nxt   = 1'b1;
          phase_nxt = gpsm_pkg::PH_IDLE;
          tick_nxt  = 10'd0;
          done      = 1'b1;
        end else begin
          tick_nxt = tick_r + 10'd1;
        end
      end
      default: begin
        phase_nxt = gpsm_pkg::PH_IDLE;
        if (start_i) begin
          sel_nxt   = 1'b0;
          phase_nxt = gpsm_pkg::PH_LEAD;
          tick_nxt  = 10'd1;
          byte_nxt  = 4'd0;
          bit_nxt   = 3'd0;
          shift_nxt = 8'd0;
        end
      end
    endcase
  end

  // state registers, advanced once per tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= gpsm_pkg::PH_IDLE;
      tick_r  <= '0;
      bit_r   <= '0;
      byte_r  <= '0;
      shift_r <= '0;
      mode_r  <= '0;
      sel_r   <= 1'b1;
      sdo_r   <= 1'b1;
      sck_r   <= 1'b1;
      for (int i = 0; i < gpsm_pkg::NumData; i++) data_r[i] <= gpsm_pkg::DataRst;
    end else if (step_i) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      bit_r   <= bit_nxt;
      byte_r  <= byte_nxt;
      shift_r <= shift_nxt;
      mode_r  <= mode_nxt;
      sel_r   <= sel_nxt;
      sdo_r   <= sdo_nxt;
      sck_r   <= sck_nxt;
      data_r  <= data_nxt;
    end
  end

  // result word reflects the state after this tick
  always_comb begin
    res_o.clock_out    = sck_nxt;
    res_o.data_out     = sdo_nxt;
    res_o.select_n     = sel_nxt;
    res_o.busy_res     = (phase_nxt != gpsm_pkg::PH_IDLE);
    res_o.poll_done    = done;
    res_o.mode_byte    = mode_nxt;
    res_o.buttons_low  = data_nxt[0];
    res_o.buttons_high = data_nxt[1];
    res_o.right_x      = data_nxt[2];
    res_o.right_y      = data_nxt[3];
    res_o.left_x       = data_nxt[4];
    res_o.left_y       = data_nxt[5];
  end

`ifndef SYNTHESIS
  // select is low exactly while a transaction runs
  a_sel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r == (phase_r == gpsm_pkg::PH_IDLE))
    else $error("select level disagrees with phase");

  // clock pin follows the half-bit phase
  a_clk_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == gpsm_pkg::PH_LOW) |-> !sck_r)
    else $error("clock high during low half");

  a_clk_high: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == gpsm_pkg::PH_HIGH) |-> sck_r)
    else $error("clock low during high half");

  // byte counter never passes the last analog byte
  a_byte_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_r <= gpsm_pkg::LastData)
    else $error("byte index out of range");

  // bit position holds on a tick of the low half
  a_bit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (step_i && phase_r == gpsm_pkg::PH_LOW) |=> $stable(bit_r))
    else $error("bit index moved in low half");
`endif

endmodule
